// ===== sv/fcnsa_pkg.sv =====
package fcnsa_pkg;

  localparam int COORD_W = 12;
  localparam int OFF_W = 26;
  localparam int REG_W = 13;
  localparam int BPP_W = 3;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_DIM_DEFAULT = 4096;
  localparam int BPP_MAX = 4;
  // Every written framebuffer pixel occupies four bytes.
  localparam int DST_BPP = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BPP = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_BPP = CFG_IDX_W'(5);

  localparam logic [REG_W-1:0] RST_SOURCE_WIDTH = REG_W'(640);
  localparam logic [REG_W-1:0] RST_SOURCE_HEIGHT = REG_W'(480);
  localparam logic [BPP_W-1:0] RST_SOURCE_BPP = BPP_W'(3);
  localparam logic [REG_W-1:0] RST_SCREEN_WIDTH = REG_W'(800);
  localparam logic [REG_W-1:0] RST_SCREEN_HEIGHT = REG_W'(480);
  localparam logic [BPP_W-1:0] RST_SCREEN_BPP = BPP_W'(4);

  typedef struct packed {
    logic [COORD_W-1:0] disp_x;
    logic [COORD_W-1:0] disp_y;
  } coord_t;

  typedef struct packed {
    logic [OFF_W-1:0] src_offset;
    logic [OFF_W-1:0] dst_offset;
    logic             in_area;
  } addr_t;

endpackage

// ===== sv/fit_center_nearest_scaler_addr.sv =====
// Stages M, D0, D1..DQW, P, T and O are registered. Throughput: one coordinate per cycle, set by
// the pipelined one-bit-per-stage divider lanes, whenever coord_ready is high.
// Reset (synchronous, active high) loads the register defaults and empties the pipeline.
// After reset and after every register write the geometry sequencer runs through
// its states, during which coord_ready is low, and then stays in ST_RUN.
module fit_center_nearest_scaler_addr #(
  parameter int MAX_DIM = fcnsa_pkg::MAX_DIM_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               coord_valid,
  output logic                               coord_ready,
  input  fcnsa_pkg::coord_t                  coord,
  output logic                               addr_valid,
  input  logic                               addr_ready,
  output fcnsa_pkg::addr_t                   addr,
  input  logic                               cfg_we,
  input  logic [fcnsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fcnsa_pkg::REG_W-1:0]        cfg_data
);
  import fcnsa_pkg::*;

  // Width of a clamped dimension, and of an in-area source index quotient (below MAX_DIM).
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int QW = $clog2(MAX_DIM);
  // The remainder lanes must hold both coord*dim and the largest shifted divisor.
  localparam int NUM_W = COORD_W + DIM_W;
  localparam int CW = DIM_W + QW;
  localparam int RW = (NUM_W > CW) ? NUM_W : CW;
  localparam int PITCH_W = DIM_W + BPP_W;
  localparam int CNT_W = $clog2(2 * DIM_W);

  localparam logic [2:0] ST_CLAMP = 3'd0;
  localparam logic [2:0] ST_MUL = 3'd1;
  localparam logic [2:0] ST_CMP = 3'd2;
  localparam logic [2:0] ST_DIV = 3'd3;
  localparam logic [2:0] ST_FIN = 3'd4;
  localparam logic [2:0] ST_RUN = 3'd5;

  typedef struct packed {
    logic             in_area;
    logic [RW-1:0]    rem_x;
    logic [RW-1:0]    rem_y;
    logic [QW-1:0]    qx;
    logic [QW-1:0]    qy;
    logic [OFF_W-1:0] dst;
  } dstage_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [REG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  function automatic logic [BPP_W-1:0] clamp_bpp(input logic [BPP_W-1:0] v);
    logic [BPP_W-1:0] r;
    if (v == '0) begin
      r = BPP_W'(1);
    end else if (int'(v) > BPP_MAX) begin
      r = BPP_W'(BPP_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers, written straight from the port.
  // ---------------------------------------------------------------------------
  logic [REG_W-1:0] source_width;
  logic [REG_W-1:0] source_height;
  logic [BPP_W-1:0] source_bpp;
  logic [REG_W-1:0] screen_width;
  logic [REG_W-1:0] screen_height;
  logic [BPP_W-1:0] screen_bpp;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= RST_SOURCE_WIDTH;
      source_height <= RST_SOURCE_HEIGHT;
      source_bpp    <= RST_SOURCE_BPP;
      screen_width  <= RST_SCREEN_WIDTH;
      screen_height <= RST_SCREEN_HEIGHT;
      screen_bpp    <= RST_SCREEN_BPP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        REG_SOURCE_BPP:    source_bpp    <= cfg_data[BPP_W-1:0];
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        REG_SCREEN_BPP:    screen_bpp    <= cfg_data[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Geometry sequencer. Every write restarts it. It clamps the registers,
  // forms the screen line pitch, decides which side limits the fit by
  // cross-multiplying the two ratios, runs one restoring division (one quotient
  // bit per cycle) for the floored side, and then derives the centering offsets.
  // Coordinates are only taken once it reaches ST_RUN.
  // ---------------------------------------------------------------------------
  logic [2:0]         state;
  logic [CNT_W-1:0]   div_cnt;
  logic [DIM_W-1:0]   iw, ih, sw, sh;
  logic [BPP_W-1:0]   spp, dpp;
  logic [2*DIM_W-1:0] prod_h;    // screen_height * source_width
  logic [2*DIM_W-1:0] prod_w;    // screen_width * source_height
  logic [PITCH_W-1:0] pitch;
  logic               shrink;
  logic               use_h;
  logic [2*DIM_W-1:0] div_num;
  logic [DIM_W-1:0]   div_den;
  logic [DIM_W-1:0]   div_rem;
  logic [DIM_W-1:0]   div_quo;
  logic [DIM_W-1:0]   dw, dh, x0, y0;

  logic [DIM_W:0]     div_trial;
  logic               div_take;
  logic [DIM_W-1:0]   dw_next, dh_next;

  assign div_trial = {div_rem, div_num[2*DIM_W-1]};
  assign div_take  = (div_trial >= {1'b0, div_den});

  // The displayed size: the source itself when it fits, otherwise the limiting
  // side takes the screen size and the other side is the floored quotient.
  always_comb begin
    dw_next = iw;
    dh_next = ih;
    if (shrink) begin
      if (use_h) begin
        dh_next = sh;
        dw_next = div_quo;
      end else begin
        dw_next = sw;
        dh_next = div_quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLAMP;
      div_cnt <= '0;
    end else if (cfg_we) begin
      state   <= ST_CLAMP;
      div_cnt <= '0;
    end else begin
      unique case (state)
        ST_CLAMP: state <= ST_MUL;
        ST_MUL:   state <= ST_CMP;
        ST_CMP: begin
          state   <= ST_DIV;
          div_cnt <= '0;
        end
        ST_DIV: begin
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(2 * DIM_W - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN:   state <= ST_RUN;
        ST_RUN:   state <= ST_RUN;
        default:  state <= ST_CLAMP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_CLAMP: begin
        iw  <= clamp_dim(source_width);
        ih  <= clamp_dim(source_height);
        sw  <= clamp_dim(screen_width);
        sh  <= clamp_dim(screen_height);
        spp <= clamp_bpp(source_bpp);
        dpp <= clamp_bpp(screen_bpp);
      end
      ST_MUL: begin
        prod_h <= (2*DIM_W)'(sh) * (2*DIM_W)'(iw);
        prod_w <= (2*DIM_W)'(sw) * (2*DIM_W)'(ih);
        pitch  <= PITCH_W'(sw) * PITCH_W'(dpp);
        shrink <= (iw > sw) || (ih > sh);
      end
      ST_CMP: begin
        // A strictly smaller height ratio limits the fit; ties use the width.
        use_h   <= (prod_h < prod_w);
        div_num <= (prod_h < prod_w) ? prod_h : prod_w;
        div_den <= (prod_h < prod_w) ? ih : iw;
        div_rem <= '0;
        div_quo <= '0;
      end
      ST_DIV: begin
        div_num <= {div_num[2*DIM_W-2:0], 1'b0};
        div_rem <= div_take ? DIM_W'(div_trial - {1'b0, div_den}) : div_trial[DIM_W-1:0];
        div_quo <= {div_quo[DIM_W-2:0], div_take};
      end
      ST_FIN: begin
        dw <= dw_next;
        dh <= dh_next;
        x0 <= (sw - dw_next) >> 1;
        y0 <= (sh - dh_next) >> 1;
      end
      ST_RUN: ;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Coordinate pipeline. Every stage has its own valid bit and takes a new
  // entry whenever it is empty or its successor is taking its entry, so bubbles
  // close up while the output is stalled and nothing is dropped or repeated.
  // Stages: M (products and framebuffer row), D0 (framebuffer offset sum),
  // D1..DQW (one quotient bit per stage for both source axes), P (row times
  // width), T (add column), O (scale by source bytes and hold the result).
  // ---------------------------------------------------------------------------
  logic               m_vld, m_rdy;
  logic               m_in_area;
  logic [RW-1:0]      m_rem_x, m_rem_y;
  logic [OFF_W-1:0]   m_dst_row, m_dst_col;

  logic [QW:0]        dv_vld, dv_rdy;
  dstage_t            dv [QW+1];

  logic               p_vld, p_rdy;
  logic               p_in_area;
  logic [OFF_W-1:0]   p_prod;
  logic [QW-1:0]      p_qx;
  logic [OFF_W-1:0]   p_dst;

  logic               t_vld, t_rdy;
  logic               t_in_area;
  logic [OFF_W-1:0]   t_idx;
  logic [OFF_W-1:0]   t_dst;

  logic               o_vld, o_rdy;

  assign o_rdy       = !o_vld || addr_ready;
  assign t_rdy       = !t_vld || o_rdy;
  assign p_rdy       = !p_vld || t_rdy;
  assign dv_rdy[QW]  = !dv_vld[QW] || p_rdy;
  assign m_rdy       = !m_vld || dv_rdy[0];
  assign coord_ready = (state == ST_RUN) && m_rdy;
  assign addr_valid  = o_vld;

  // Stage M
  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (m_rdy) begin
      m_vld <= coord_valid && (state == ST_RUN);
    end
  end

  always_ff @(posedge clk) begin
    if (m_rdy) begin
      m_in_area <= (RW'(coord.disp_x) < RW'(dw)) && (RW'(coord.disp_y) < RW'(dh));
      m_rem_x   <= RW'(coord.disp_x) * RW'(iw);
      m_rem_y   <= RW'(coord.disp_y) * RW'(ih);
      m_dst_row <= (OFF_W'(y0) + OFF_W'(coord.disp_y)) * OFF_W'(pitch);
      m_dst_col <= (OFF_W'(x0) + OFF_W'(coord.disp_x)) * OFF_W'(DST_BPP);
    end
  end

  // Stage D0
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (dv_rdy[0]) begin
      dv_vld[0] <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_rdy[0]) begin
      dv[0].in_area <= m_in_area;
      dv[0].rem_x   <= m_rem_x;
      dv[0].rem_y   <= m_rem_y;
      dv[0].qx      <= '0;
      dv[0].qy      <= '0;
      dv[0].dst     <= m_dst_row + m_dst_col;
    end
  end

  // Stages D1..DQW: restoring division, most significant quotient bit first.
  // Inside the displayed area the quotient is below the source dimension, so QW bits suffice.
  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int B = QW - k;
    dstage_t       stage_next;
    logic [RW-1:0] sub_x, sub_y;

    // A divider stage is blocked only when it and every stage after it are
    // full and stage P cannot move.
    assign dv_rdy[k-1] = !(&dv_vld[QW:k-1]) || p_rdy;

    assign sub_x = RW'(dw) << B;
    assign sub_y = RW'(dh) << B;

    always_comb begin
      stage_next = dv[k-1];
      if (dv[k-1].rem_x >= sub_x) begin
        stage_next.rem_x = dv[k-1].rem_x - sub_x;
        stage_next.qx[B] = 1'b1;
      end
      if (dv[k-1].rem_y >= sub_y) begin
        stage_next.rem_y = dv[k-1].rem_y - sub_y;
        stage_next.qy[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k] <= 1'b0;
      end else if (dv_rdy[k]) begin
        dv_vld[k] <= dv_vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (dv_rdy[k]) begin
        dv[k] <= stage_next;
      end
    end
  end

  // Stage P
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (p_rdy) begin
      p_vld <= dv_vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (p_rdy) begin
      p_in_area <= dv[QW].in_area;
      p_prod    <= OFF_W'(dv[QW].qy) * OFF_W'(iw);
      p_qx      <= dv[QW].qx;
      p_dst     <= dv[QW].dst;
    end
  end

  // Stage T
  always_ff @(posedge clk) begin
    if (rst) begin
      t_vld <= 1'b0;
    end else if (t_rdy) begin
      t_vld <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (t_rdy) begin
      t_in_area <= p_in_area;
      t_idx     <= p_prod + OFF_W'(p_qx);
      t_dst     <= p_dst;
    end
  end

  // Stage O: the output register. Coordinates outside the displayed area
  // give zero offsets with in_area low.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (o_rdy) begin
      o_vld <= t_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      addr.in_area    <= t_in_area;
      addr.src_offset <= t_in_area ? t_idx * OFF_W'(spp) : '0;
      addr.dst_offset <= t_in_area ? t_dst : '0;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fcnsa_pkg::*;

  localparam int unsigned MAX_DIM = MAX_DIM_DEFAULT;
  // A run at full receiver stall and with every register write ends well inside this
  // limit, so the limit only catches a hang.
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned N_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 50;
  // The result pipeline is 17 deep at the default size. Leave some slack after the
  // last transfer, so that a stray extra result is still seen.
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 10;

  // Indexes past the last register. Writes to them must leave the geometry alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);

  // Signals of the block under test. Every input has a known value from time zero.
  logic                 clk;
  logic                 rst = 1'b1;
  logic                 coord_valid = 1'b0;
  logic                 coord_ready;
  coord_t               coord = '0;
  logic                 addr_valid;
  logic                 addr_ready = 1'b0;
  addr_t                addr;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;

  fit_center_nearest_scaler_addr #(
    .MAX_DIM(MAX_DIM)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .coord_valid(coord_valid),
    .coord_ready(coord_ready),
    .coord      (coord),
    .addr_valid (addr_valid),
    .addr_ready (addr_ready),
    .addr       (addr),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // The testbench keeps its own copy of the six registers as the block should
  // hold them: dimensions at 13 bits, bytes per pixel cut down to 3 bits.
  logic [REG_W-1:0] src_w_reg = RST_SOURCE_WIDTH;
  logic [REG_W-1:0] src_h_reg = RST_SOURCE_HEIGHT;
  logic [BPP_W-1:0] src_bpp_reg = RST_SOURCE_BPP;
  logic [REG_W-1:0] scr_w_reg = RST_SCREEN_WIDTH;
  logic [REG_W-1:0] scr_h_reg = RST_SCREEN_HEIGHT;
  logic [BPP_W-1:0] scr_bpp_reg = RST_SCREEN_BPP;

  // The displayed rectangle, with all register values already saturated.
  typedef struct {
    longint unsigned iw, ih, sw, sh, dw, dh;
  } geometry_t;

  // One address still owed by the block, together with the coordinate that
  // caused it, so that a mismatch report can name the pixel.
  typedef struct {
    coord_t xy;
    addr_t  result;
  } addr_expect_t;

  addr_expect_t expected_addrs[$];
  int unsigned  error_count = 0;
  int unsigned  src_idle_pct = 0;
  int unsigned  sink_idle_pct = 0;

  // Directed stimulus. A row either writes a register, sends a coordinate whose
  // address comes from the predictor, or sends one with the address typed in.
  typedef enum logic [1:0] {ROW_WRITE, ROW_PREDICT, ROW_TYPED} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [REG_W-1:0]     data;
    coord_t               xy;
    addr_t                result;
  } stim_row_t;

  localparam int unsigned N_DIRECTED = 48;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // Reset geometry: a 640x480 image fits an 800x480 screen, so it is centered
    // with an 80 pixel margin on the left and right.
    '{ROW_TYPED,   REG_SOURCE_WIDTH,  '0,         '{12'd0,    12'd0},    '{26'd0, 26'd320, 1'b1}},
    '{ROW_TYPED,   REG_SOURCE_WIDTH,  '0,         '{12'd639,  12'd479},
      '{26'd921597, 26'd1535676, 1'b1}},
    '{ROW_TYPED,   REG_SOURCE_WIDTH,  '0,         '{12'd640,  12'd0},    '0},
    '{ROW_TYPED,   REG_SOURCE_WIDTH,  '0,         '{12'd0,    12'd480},  '0},
    '{ROW_TYPED,   REG_SOURCE_WIDTH,  '0,         '{12'd4095, 12'd4095}, '0},
    // A wide image is shrunk by the width ratio.
    '{ROW_WRITE,   REG_SOURCE_WIDTH,  13'd1920,   '0,                    '0},
    '{ROW_WRITE,   REG_SOURCE_HEIGHT, 13'd1080,   '0,                    '0},
    '{ROW_PREDICT, REG_SOURCE_WIDTH,  '0,         '{12'd0,    12'd0},    '0},
    '{ROW_PREDICT, REG_SOURCE_WIDTH,  '0,         '{12'd799,  12'd449},  '0},
    '{ROW_PREDICT, REG_SOURCE_WIDTH,  '0,         '{12'd800,  12'd0},    '0},
    '{ROW_PREDICT, REG_SOURCE_WIDTH,  '0,         '{12'd0,    12'd450},  '0},
    // A tall image is shrunk by the height ratio into a narrow strip.
    '{ROW_WRITE,   REG_SOURCE_WIDTH,  13'd100,    '0,                    '0},
    '{ROW_WRITE,   REG_SOURCE_HEIGHT, 13'd4096,   '0,                    '0},
    '{ROW_PREDICT, REG_SOURCE_WIDTH,  '0,         '{12'd10,   12'd479},  '0},
    '{ROW_PREDICT, REG_SOURCE_WIDTH,  '0,         '{12'd11,   12'd0},    '0},
    // Zero and oversize dimensions saturate. A 1x4096 image floors to zero width,
    // so nothing is displayed at all.
    '{ROW_WRITE,   REG_SOURCE_WIDTH,  13'd0,      '0,                    '0},
    '{ROW_WRITE,   REG_SOURCE_HEIGHT, 13'd8191,   '0,                    '0},
    '{ROW_WRITE,   REG_SOURCE_BPP,    13'd0,      '0,                    '0},
    '{ROW_TYPED,   REG_SOURCE_WIDTH,  '0,         '{12'd0,    12'd0},    '0},
    // Largest image on the largest screen, bytes per pixel above the maximum.
    '{ROW_WRITE,   REG_SOURCE_WIDTH,  13'd4096,   '0,                    '0},
    '{ROW_WRITE,   REG_SOURCE_HEIGHT, 13'd4096,   '0,                    '0},
    '{ROW_WRITE,   REG_SOURCE_BPP,    13'd7,      '0,                    '0},
    '{ROW_WRITE,   REG_SCREEN_WIDTH,  13'd4096,   '0,                    '0},
    '{ROW_WRITE,   REG_SCREEN_HEIGHT, 13'd4096,   '0,                    '0},
    '{ROW_WRITE,   REG_SCREEN_BPP,    13'd5,      '0,                    '0},
    '{ROW_PREDICT, REG_SOURCE_WIDTH,  '0,         '{12'd4095, 12'd4095}, '0},
    '{ROW_TYPED,   REG_SOURCE_WIDTH,  '0,         '{12'd0,    12'd0},    '{26'd0, 26'd0, 1'b1}},
    // A one-line screen: the image collapses to a single displayed pixel.
    '{ROW_WRITE,   REG_SCREEN_BPP,    13'd0,      '0,                    '0},
    '{ROW_WRITE,   REG_SCREEN_WIDTH,  13'd8191,   '0,                    '0},
    '{ROW_WRITE,   REG_SCREEN_HEIGHT, 13'd0,      '0,                    '0},
    '{ROW_PREDICT, REG_SOURCE_WIDTH,  '0,         '{12'd0,    12'd0},    '0},
    '{ROW_PREDICT, REG_SOURCE_WIDTH,  '0,         '{12'd1,    12'd0},    '0},
    // Writes to unknown indexes are dropped.
    '{ROW_WRITE,   REG_SPARE_LO,      13'd8191,   '0,                    '0},
    '{ROW_WRITE,   REG_SPARE_HI,      13'd0,      '0,                    '0},
    '{ROW_PREDICT, REG_SOURCE_WIDTH,  '0,         '{12'd0,    12'd0},    '0},
    // Both ratios equal: the width ratio wins, and the image fills the screen.
    '{ROW_WRITE,   REG_SOURCE_WIDTH,  13'd1600,   '0,                    '0},
    '{ROW_WRITE,   REG_SOURCE_HEIGHT, 13'd960,    '0,                    '0},
    '{ROW_WRITE,   REG_SOURCE_BPP,    13'd4,      '0,                    '0},
    '{ROW_WRITE,   REG_SCREEN_WIDTH,  13'd800,    '0,                    '0},
    '{ROW_WRITE,   REG_SCREEN_HEIGHT, 13'd480,    '0,                    '0},
    '{ROW_WRITE,   REG_SCREEN_BPP,    13'd3,      '0,                    '0},
    '{ROW_PREDICT, REG_SOURCE_WIDTH,  '0,         '{12'd799,  12'd479},  '0},
    '{ROW_PREDICT, REG_SOURCE_WIDTH,  '0,         '{12'd400,  12'd240},  '0},
    '{ROW_PREDICT, REG_SOURCE_WIDTH,  '0,         '{12'd0,    12'd479},  '0},
    // A tiny image sits in the middle of the screen at its own size.
    '{ROW_WRITE,   REG_SOURCE_WIDTH,  13'd3,      '0,                    '0},
    '{ROW_WRITE,   REG_SOURCE_HEIGHT, 13'd5,      '0,                    '0},
    '{ROW_PREDICT, REG_SOURCE_WIDTH,  '0,         '{12'd2,    12'd4},    '0},
    '{ROW_PREDICT, REG_SOURCE_WIDTH,  '0,         '{12'd3,    12'd4},    '0}
  };

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run-away guard: if the run has not ended by now, something hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // The receiver stalls at random, at the rate that the current phase sets.
  always @(negedge clk) begin
    addr_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  function automatic longint unsigned sat_range(longint unsigned v, longint unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  // Size of the displayed area. An image larger than the screen on either side is
  // shrunk by the smaller ratio, kept exact by cross-multiplying: the limiting side
  // takes the screen size, the other side is floored.
  function automatic geometry_t fit_geometry();
    geometry_t g;
    g.iw = sat_range(src_w_reg, MAX_DIM);
    g.ih = sat_range(src_h_reg, MAX_DIM);
    g.sw = sat_range(scr_w_reg, MAX_DIM);
    g.sh = sat_range(scr_h_reg, MAX_DIM);
    g.dw = g.iw;
    g.dh = g.ih;
    if (g.iw > g.sw || g.ih > g.sh) begin
      if (g.sh * g.iw < g.sw * g.ih) begin
        g.dh = g.sh;
        g.dw = (g.iw * g.sh) / g.ih;
      end else begin
        g.dw = g.sw;
        g.dh = (g.ih * g.sw) / g.iw;
      end
    end
    return g;
  endfunction

  // Address pair for one display coordinate under the current registers. Outside
  // the displayed area everything reads zero.
  function automatic addr_t predict_addr(coord_t xy);
    geometry_t       g;
    longint unsigned x, y, sx, sy, x0, y0, src_bytes, scr_bytes;
    addr_t           a;
    g = fit_geometry();
    x = xy.disp_x;
    y = xy.disp_y;
    a = '0;
    if (x < g.dw && y < g.dh) begin
      src_bytes = sat_range(src_bpp_reg, BPP_MAX);
      scr_bytes = sat_range(scr_bpp_reg, BPP_MAX);
      x0 = (g.sw - g.dw) / 2;
      y0 = (g.sh - g.dh) / 2;
      sx = (x * g.iw) / g.dw;
      sy = (y * g.ih) / g.dh;
      a.src_offset = OFF_W'((sy * g.iw + sx) * src_bytes);
      a.dst_offset = OFF_W'((y0 + y) * (g.sw * scr_bytes) + (x0 + x) * DST_BPP);
      a.in_area = 1'b1;
    end
    return a;
  endfunction

  // Random dimension register value, leaning on the saturation corners and on
  // small images, which are the ones that leave room for letterboxing.
  function automatic logic [REG_W-1:0] rand_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return REG_W'($urandom_range(MAX_DIM + 1, (1 << REG_W) - 1));
      2: return REG_W'(MAX_DIM);
      3: return REG_W'(1);
      4, 5: return REG_W'($urandom_range(1, 64));
      default: return REG_W'($urandom_range(1, MAX_DIM));
    endcase
  endfunction

  // Stop sending and wait at a falling edge until every owed address is back.
  // It always waits on a falling edge before returning, so that the valid drop
  // and a following raise never share a time step.
  task automatic drain();
    coord_valid <= 1'b0;
    do @(negedge clk); while (expected_addrs.size() != 0);
  endtask

  // One register write. Registers only change while nothing is in flight, so the
  // predictor copy can follow at once. The write strobe stays up until the sender
  // starts on the next coordinate, which lets back-to-back writes run one per cycle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
    if (expected_addrs.size() != 0) drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_SOURCE_WIDTH:  src_w_reg = data;
      REG_SOURCE_HEIGHT: src_h_reg = data;
      REG_SOURCE_BPP:    src_bpp_reg = data[BPP_W-1:0];
      REG_SCREEN_WIDTH:  scr_w_reg = data;
      REG_SCREEN_HEIGHT: scr_h_reg = data;
      REG_SCREEN_BPP:    scr_bpp_reg = data[BPP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Offer one coordinate, starting at a falling edge. The sender may idle first;
  // once valid is up it holds, with the same payload, until the transfer. The
  // expectation is queued at the rising edge that takes the transfer.
  task automatic send_coord(coord_t xy, addr_t result);
    addr_expect_t e;
    cfg_we <= 1'b0;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      coord_valid <= 1'b0;
      @(negedge clk);
    end
    coord_valid <= 1'b1;
    coord <= xy;
    do @(posedge clk); while (!coord_ready);
    e.xy = xy;
    e.result = result;
    expected_addrs.push_back(e);
    @(negedge clk);
  endtask

  // Every address transfer is matched against the oldest owed address. Sampling
  // at the rising edge sees the values the block drove before that edge.
  always @(posedge clk) begin : check_addr
    addr_expect_t want;
    if (!rst && addr_valid && addr_ready) begin
      if (expected_addrs.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected address transfer: src=%0d dst=%0d in_area=%0b",
                   addr.src_offset, addr.dst_offset, addr.in_area);
      end else begin
        want = expected_addrs.pop_front();
        if (addr.src_offset !== want.result.src_offset ||
            addr.dst_offset !== want.result.dst_offset ||
            addr.in_area !== want.result.in_area) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("address mismatch at (%0d,%0d): expected src=%0d dst=%0d in_area=%0b, got src=%0d dst=%0d in_area=%0b",
                     want.xy.disp_x, want.xy.disp_y,
                     want.result.src_offset, want.result.dst_offset, want.result.in_area,
                     addr.src_offset, addr.dst_offset, addr.in_area);
        end
      end
    end
  end

  initial begin : stimulus
    coord_t    xy;
    geometry_t g;
    int unsigned sel;

    // Reset is held from time zero and released at a falling edge. The block then runs its
    // geometry pass with coord_ready low; the handshake takes care of that.
    src_idle_pct = 13;
    sink_idle_pct = 63;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: corners of the reset geometry, both shrink directions,
    // saturation, an empty area, equal ratios and a small centered image.
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_WRITE:   write_reg(directed_rows[i].idx, directed_rows[i].data);
        ROW_TYPED:   send_coord(directed_rows[i].xy, directed_rows[i].result);
        default:     send_coord(directed_rows[i].xy, predict_addr(directed_rows[i].xy));
      endcase
    end

    // Random part. Each phase loads a new geometry, then scans mostly inside the
    // displayed area, with some coordinates on or just past its edges and some
    // anywhere in the 12-bit range. The first phases stall the receiver hard,
    // the middle ones the sender, and the last ones run flat out.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      src_idle_pct = (phase < 4) ? 13 : ((phase < 7) ? 63 : 0);
      sink_idle_pct = (phase < 4) ? 63 : ((phase < 7) ? 13 : 0);
      write_reg(REG_SOURCE_WIDTH, rand_dim());
      write_reg(REG_SOURCE_HEIGHT, rand_dim());
      write_reg(REG_SCREEN_WIDTH, rand_dim());
      write_reg(REG_SCREEN_HEIGHT, rand_dim());
      // Full 13-bit data on the byte-count registers: only the low three bits count.
      write_reg(REG_SOURCE_BPP, REG_W'($urandom));
      write_reg(REG_SCREEN_BPP, REG_W'($urandom));
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, REG_W'($urandom));
      g = fit_geometry();

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Halfway through every other phase the sender holds back until the
        // pipeline is empty, then restarts from cold.
        if (phase % 2 == 1 && k == PHASE_ITEMS / 2) drain();
        sel = $urandom_range(0, 9);
        if (sel < 2 || g.dw == 0 || g.dh == 0) begin
          xy.disp_x = COORD_W'($urandom);
          xy.disp_y = COORD_W'($urandom);
        end else begin
          xy.disp_x = COORD_W'($urandom_range(0, int'(g.dw) - 1));
          xy.disp_y = COORD_W'($urandom_range(0, int'(g.dh) - 1));
          if (sel == 2 && g.dw < MAX_DIM) xy.disp_x = COORD_W'(g.dw);
          if (sel == 3 && g.dh < MAX_DIM) xy.disp_y = COORD_W'(g.dh);
          if (sel == 4) begin
            xy.disp_x = COORD_W'(g.dw - 1);
            xy.disp_y = COORD_W'(g.dh - 1);
          end
        end
        send_coord(xy, predict_addr(xy));
      end
    end

    // Wait for the last addresses, then a little longer for anything stray.
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_addrs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
